// ===== design/huffman_code_bit_packer_top_defines.svh =====
// Assertion macros for the Huffman code bit packer.
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, off while reset is asserted.
`define HCBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define HCBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define HCBP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/hcbp_pkg.sv =====
// Package: beat types, operation codes and helpers of the bit packer.
`timescale 1ns / 1ps
package hcbp_pkg;

  // Field widths
  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int BYTE_W = 8;

  // Longest code the packer will emit; loads saturate to LEN_LIM
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_LIM      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // Table size and decoupling queue depth
  localparam int SYMBOLS_DEF = 256;
  localparam int QUEUE_DEPTH = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  // Input beat
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_len;
    logic [CODE_W-1:0] code_bits;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_t;

  // Command from front to back: code bits left-aligned, zeros below
  typedef struct packed {
    logic              flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  // Saturate a code length
  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] len);
    if (int'(len) > LEN_LIM) begin
      return LEN_W'(LEN_LIM);
    end
    return len;
  endfunction

endpackage

// ===== design/hcbp_front.sv =====
// Front end: code table, lookup stage and command issue into the queue.
`timescale 1ns / 1ps
module hcbp_front #(
  parameter int SYMBOLS = hcbp_pkg::SYMBOLS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  input  hcbp_pkg::in_t item_i,
  output logic          full,
  output logic          q_push_o,
  output hcbp_pkg::cmd_t q_cmd_o,
  input  logic          q_full_i
);
  import hcbp_pkg::*;

  localparam int IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  // Reduce a byte modulo the table size by restoring subtraction
  function automatic logic [IDX_W-1:0] wrap_sym(logic [SYM_W-1:0] s);
    logic [15:0] v;
    v = {8'b0, s};
    for (int k = SYM_W - 1; k >= 0; k--) begin
      if (v >= 16'(SYMBOLS << k)) begin
        v = v - 16'(SYMBOLS << k);
      end
    end
    return v[IDX_W-1:0];
  endfunction

  logic [LEN_W+CODE_W-1:0] table_mem [SYMBOLS];
  logic [LEN_W+CODE_W-1:0] rd_q;
  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_flush_q;
  logic                    accept;
  logic [IDX_W-1:0]        idx;
  logic [LEN_W-1:0]        rd_len;
  logic [LEN_W-1:0]        sh_amt;

  assign idx    = wrap_sym(item_i.symbol);
  assign full   = s1_valid_q && q_full_i;
  assign accept = push && !full;

  // Table write on load, registered read on every accepted beat
  always_ff @(posedge clk_i) begin
    if (accept && (item_i.operation == OP_LOAD)) begin
      table_mem[idx] <= {clamp_len(item_i.code_len), item_i.code_bits};
    end
    if (accept) begin
      rd_q       <= table_mem[idx];
      s1_flush_q <= (item_i.operation == OP_FLUSH);
    end
  end

  // Lookup stage occupancy: only encode and flush go on
  always_comb begin
    if (accept) begin
      s1_valid_d = (item_i.operation == OP_ENCODE) || (item_i.operation == OP_FLUSH);
    end else begin
      s1_valid_d = s1_valid_q && q_full_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Left-align the code; zero-length encodes are dropped
  assign rd_len = clamp_len(rd_q[LEN_W+CODE_W-1:CODE_W]);
  assign sh_amt = LEN_W'(CODE_W) - rd_len;

  always_comb begin
    q_cmd_o.flush = s1_flush_q;
    q_cmd_o.len   = rd_len;
    q_cmd_o.bits  = rd_q[CODE_W-1:0] << sh_amt;
  end

  assign q_push_o = s1_valid_q && !q_full_i && (s1_flush_q || (rd_len != '0));

endmodule

// ===== design/hcbp_queue.sv =====
// Short command queue between front end and packer.
`timescale 1ns / 1ps
module hcbp_queue #(
  parameter int DEPTH = hcbp_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hcbp_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output hcbp_pkg::cmd_t data_o
);
  import hcbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_q];

  // Pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/hcbp_back.sv =====
// Back end: bit packer with pending byte and output register.
`timescale 1ns / 1ps
module hcbp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  hcbp_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           empty,
  input  logic           pop,
  output hcbp_pkg::out_t result_o
);
  import hcbp_pkg::*;

  localparam int BC_W = $clog2(BYTE_W + 1);

  back_state_e       state_q, state_d;
  logic              flush_q, flush_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [CODE_W-1:0] bits_q, bits_d;
  logic [BYTE_W-1:0] pend_q, pend_d;
  logic [BC_W-1:0]   bc_q, bc_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  logic              slot_free;
  logic              emit;
  out_t              emit_beat;
  logic [BC_W-1:0]   avail;
  logic [BC_W-1:0]   take;

  assign slot_free = !out_valid_q || pop;
  assign avail     = BC_W'(BYTE_W) - bc_q;
  assign take      = (rem_q < LEN_W'(avail)) ? BC_W'(rem_q) : avail;

  // Packer sequencer
  always_comb begin
    state_d   = state_q;
    flush_d   = flush_q;
    rem_d     = rem_q;
    bits_d    = bits_q;
    pend_d    = pend_q;
    bc_d      = bc_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_beat = '{out_byte: pend_q, last: 1'b1};
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          flush_d = q_cmd_i.flush;
          rem_d   = q_cmd_i.len;
          bits_d  = q_cmd_i.bits;
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (flush_q) begin
          // send pending byte, zero padded, and clear
          if (slot_free) begin
            emit    = 1'b1;
            pend_d  = '0;
            bc_d    = '0;
            state_d = BK_IDLE;
          end
        end else if (bc_q == BC_W'(BYTE_W)) begin
          // a held full byte goes out when more bits follow
          if (slot_free) begin
            emit           = 1'b1;
            emit_beat.last = (rem_q <= LEN_W'(BYTE_W));
            pend_d         = '0;
            bc_d           = '0;
          end
        end else begin
          // merge as many bits as fit into the pending byte
          pend_d = pend_q | (bits_q[CODE_W-1 -: BYTE_W] >> bc_q);
          bits_d = bits_q << take;
          rem_d  = rem_q - LEN_W'(take);
          bc_d   = bc_q + take;
          if (rem_q == LEN_W'(take)) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_beat;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pend_q      <= '0;
      bc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      bc_q        <= bc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flush_q <= flush_d;
    rem_q   <= rem_d;
    bits_q  <= bits_d;
    out_q   <= out_d;
  end

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

// ===== design/huffman_code_bit_packer_top.sv =====
// Top level of the Huffman code bit packer.
//
// Input queue port: push/item_i/full. A beat is taken when push is high and
// full is low. Load beats write the code table; encode beats pack the code of
// their symbol MSB first; flush beats send the pending byte, zero padded.
// Result queue port: result_o/empty/pop. The oldest byte is shown while empty
// is low and is taken when pop is high.
// A flush taken while the packer is idle goes through the lookup stage
// register, the command queue and the packer's start state before its byte
// reaches the output register. Throughput: the front end takes one beat a
// cycle until the command queue fills. The packer starts a command, merges
// up to 8 bits at a time into its single pending byte and sends each full
// byte as a step of its own; this loop limits the throughput.
// Reset clears the pending byte, bit count and queues; the code table is
// not cleared and must be loaded before use.
// A stalled receiver holds the output register; the packer then waits and
// the command queue, then full, backs up.
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_top_defines.svh"
module huffman_code_bit_packer_top #(
  parameter int SYMBOLS = hcbp_pkg::SYMBOLS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  hcbp_pkg::in_t  item_i,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output hcbp_pkg::out_t result_o
);
  import hcbp_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wr_cmd, q_rd_cmd;

  hcbp_front #(
    .SYMBOLS (SYMBOLS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item_i),
    .full     (full),
    .q_push_o (q_push),
    .q_cmd_o  (q_wr_cmd),
    .q_full_i (q_full)
  );

  hcbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rd_cmd)
  );

  hcbp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_rd_cmd),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

  // Checks
  `HCBP_ASSERT(a_no_push_full, clk_i, rst_ni, q_push |-> !q_full, "command pushed into full queue")
  `HCBP_ASSERT(a_no_pop_empty, clk_i, rst_ni, q_pop |-> !q_empty, "command popped from empty queue")
  `HCBP_ASSERT_ALWAYS(a_full_src, clk_i, full |-> q_full, "input stalled with queue space free")

endmodule
